// ----- rtl/bmpd_pkg.sv -----
// ----------------------------------------------------------------------------
// bmpd_pkg
// Shared types and constants of the BMP pixel stream decoder: register
// indexes, pixel modes and the palette memory request record.
// ----------------------------------------------------------------------------
package bmpd_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_WIDTH   = 8'd0;
	localparam logic [7:0] REG_HEIGHT  = 8'd1;
	localparam logic [7:0] REG_MODE    = 8'd2;
	localparam logic [7:0] REG_PALETTE = 8'd3;

	// pixel modes
	localparam logic [1:0] MODE_INDEX = 2'd0;
	localparam logic [1:0] MODE_BGR   = 2'd1;
	localparam logic [1:0] MODE_BGRA  = 2'd2;

	// coordinate range of the image
	localparam int COORD_LIMIT = 4096;

	// palette memory request from the stream logic
	typedef struct packed {
		logic        we;
		logic [7:0]  waddr;
		logic [23:0] wdata;
		logic        re;
		logic [7:0]  raddr;
	} pal_req_t;

	// palette memory response, registered
	typedef struct packed {
		logic        hit;
		logic [23:0] rdata;
	} pal_rsp_t;

	// bytes per pixel of a mode; the unused code counts as 32-bit
	function automatic logic [2:0] bytes_per_pixel(input logic [1:0] mode);
		logic [2:0] n;
		case (mode)
			MODE_INDEX: n = 3'd1;
			MODE_BGR:   n = 3'd3;
			default:    n = 3'd4;
		endcase
		return n;
	endfunction

endpackage

// ----- rtl/bmpd_palette.sv -----
// ----------------------------------------------------------------------------
// bmpd_palette
// Palette memory, one write and one read port, registered read data. A valid
// bit per entry makes a read of an entry that was never written report no hit.
// ----------------------------------------------------------------------------
module bmpd_palette #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bmpd_pkg::pal_req_t req,
	output bmpd_pkg::pal_rsp_t rsp
);
	import bmpd_pkg::*;

	localparam int IW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

	logic [23:0]                mem [PALETTE_ENTRIES];
	logic [PALETTE_ENTRIES-1:0] valid_q;
	logic [23:0]                rdata_q;
	logic                       hit_q;
	logic                       in_range;

	assign in_range = {1'b0, req.raddr} < 9'(PALETTE_ENTRIES);

	// memory array: write and registered read
	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr[IW-1:0]] <= req.wdata;
		end
		if (req.re) begin
			rdata_q <= mem[req.raddr[IW-1:0]];
		end
	end

	// per-entry valid bits and read hit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			hit_q   <= 1'b0;
		end else begin
			if (req.we) begin
				valid_q[req.waddr[IW-1:0]] <= 1'b1;
			end
			if (req.re) begin
				hit_q <= in_range && valid_q[req.raddr[IW-1:0]];
			end
		end
	end

	assign rsp.hit   = hit_q;
	assign rsp.rdata = rdata_q;

endmodule

// ----- rtl/bmp_pixel_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// bmp_pixel_stream_decoder
// Decodes the palette and pixel array of a BMP stream, one byte per transfer,
// into pixels with coordinates and B,G,R,A components.
// ----------------------------------------------------------------------------
//  channel  signals                                   direction
//  in       in_valid, in_ready, data_byte             into block
//  out      out_valid, out_ready, pixel_x .. last_pix  out of block
//  cfg      cfg_valid, cfg_ready, cfg_index, cfg_data  into block
//
//  One byte is accepted every clock while in_ready is high; the last byte
//  of a pixel passes the palette read stage, then the output register.
//  Reset clears the palette valid bits at once; no clearing pass is needed.
//  A stalled output holds the read stage; input stalls only when both the
//  read stage and the output register are full.
//  Configuration writes are always accepted.
// ----------------------------------------------------------------------------
module bmp_pixel_stream_decoder #(
	parameter int MAX_WIDTH       = 4096,
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	// byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  data_byte,
	// pixels
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] pixel_x,
	output logic [11:0] pixel_y,
	output logic [7:0]  blue,
	output logic [7:0]  green,
	output logic [7:0]  red,
	output logic [7:0]  alpha,
	output logic        raw_grey,
	output logic        last_pixel,
	// configuration
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	import bmpd_pkg::*;

	localparam int W_LIMIT = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;

	// configuration registers
	logic [12:0] width_q;
	logic [12:0] height_q;
	logic [1:0]  mode_q;
	logic [8:0]  pal_count_q;

	// stream state
	logic [10:0] pal_bytes_q;
	logic [15:0] pal_part_q;
	logic [1:0]  bip_q;
	logic [23:0] pix_part_q;
	logic [11:0] col_q;
	logic [11:0] row_q;
	logic [1:0]  pad_q;

	// read stage
	logic        s1_v_q;
	logic [11:0] x_s1, y_s1;
	logic [23:0] color_s1;
	logic [7:0]  alpha_s1;
	logic        raw_s1, last_s1, look_s1;

	// output register
	logic        out_v_q;
	logic [11:0] x_q, y_q;
	logic [23:0] color_q;
	logic [7:0]  alpha_q;
	logic        raw_q, last_q;

	logic        in_fire, cfg_fire, s1_move;
	logic [12:0] eff_w, eff_h, cfg_h;
	logic [8:0]  eff_pal;
	logic [2:0]  bpp;
	logic        pal_phase, pad_phase, gather, emit, row_end;
	logic [1:0]  wn_lo;
	logic [23:0] pix_color;
	logic [7:0]  pix_alpha;
	logic        pix_raw, pix_look;
	pal_req_t    pal_req;
	pal_rsp_t    pal_rsp;

	// handshakes
	assign cfg_ready = 1'b1;
	assign cfg_fire  = cfg_valid && cfg_ready;
	assign s1_move   = !out_v_q || out_ready;
	assign in_ready  = !s1_v_q || s1_move;
	assign in_fire   = in_valid && in_ready;

	// effective configuration
	always_comb begin
		if (width_q == 13'd0)              eff_w = 13'd1;
		else if (width_q > 13'(W_LIMIT))   eff_w = 13'(W_LIMIT);
		else                               eff_w = width_q;
		if (height_q == 13'd0)             eff_h = 13'd1;
		else if (height_q > 13'(COORD_LIMIT)) eff_h = 13'(COORD_LIMIT);
		else                               eff_h = height_q;
		if (cfg_data[12:0] == 13'd0)       cfg_h = 13'd1;
		else if (cfg_data[12:0] > 13'(COORD_LIMIT)) cfg_h = 13'(COORD_LIMIT);
		else                               cfg_h = cfg_data[12:0];
		if (pal_count_q > 9'(PALETTE_ENTRIES)) eff_pal = 9'(PALETTE_ENTRIES);
		else                               eff_pal = pal_count_q;
	end

	assign bpp = bytes_per_pixel(mode_q);

	// byte classification
	assign pal_phase = pal_bytes_q < {eff_pal, 2'b00};
	assign pad_phase = !pal_phase && (pad_q != 2'd0);
	assign gather    = !pal_phase && !pad_phase && (({1'b0, bip_q} + 3'd1) < bpp);
	assign emit      = !pal_phase && !pad_phase && !gather;
	assign row_end   = ({1'b0, col_q} + 13'd1) >= eff_w;
	assign wn_lo     = 2'(eff_w[1:0] * bpp[1:0]);

	// pixel assembled from this byte
	always_comb begin
		pix_color = '0;
		pix_alpha = '0;
		pix_raw   = 1'b0;
		pix_look  = 1'b0;
		case (bpp)
			3'd1: begin
				if (eff_pal != 9'd0) begin
					pix_look = 1'b1;
				end else begin
					pix_color = {16'h0000, data_byte};
					pix_raw   = 1'b1;
				end
			end
			3'd3: pix_color = {data_byte, pix_part_q[15:0]};
			default: begin
				pix_color = pix_part_q;
				pix_alpha = data_byte;
			end
		endcase
	end

	// palette memory access; a write and a read never fall on one byte, and
	// a read issued after a write sees the written entry
	always_comb begin
		pal_req.we    = in_fire && pal_phase && (pal_bytes_q[1:0] == 2'd2);
		pal_req.waddr = pal_bytes_q[9:2];
		pal_req.wdata = {data_byte, pal_part_q};
		pal_req.re    = in_fire && emit && pix_look;
		pal_req.raddr = data_byte;
	end

	bmpd_palette #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_palette (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (pal_req),
		.rsp   (pal_rsp)
	);

	// configuration and stream state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q     <= 13'd1;
			height_q    <= 13'd1;
			mode_q      <= MODE_INDEX;
			pal_count_q <= '0;
			pal_bytes_q <= '0;
			pal_part_q  <= '0;
			bip_q       <= '0;
			pix_part_q  <= '0;
			col_q       <= '0;
			row_q       <= '0;
			pad_q       <= '0;
		end else begin
			if (cfg_fire) begin
				case (cfg_index)
					REG_WIDTH:   width_q <= cfg_data[12:0];
					REG_HEIGHT: begin
						height_q <= cfg_data[12:0];
						row_q    <= 12'(cfg_h - 13'd1);
					end
					REG_MODE:    mode_q <= cfg_data[1:0];
					REG_PALETTE: pal_count_q <= cfg_data[8:0];
					default: ;
				endcase
			end
			if (in_fire) begin
				if (pal_phase) begin
					pal_bytes_q <= pal_bytes_q + 11'd1;
					case (pal_bytes_q[1:0])
						2'd0:    pal_part_q <= {8'h00, data_byte};
						2'd1:    pal_part_q[15:8] <= data_byte;
						default: ;
					endcase
				end else if (pad_phase) begin
					pad_q <= pad_q - 2'd1;
				end else if (gather) begin
					case (bip_q)
						2'd0:    pix_part_q[7:0]   <= data_byte;
						2'd1:    pix_part_q[15:8]  <= data_byte;
						default: pix_part_q[23:16] <= data_byte;
					endcase
					bip_q <= bip_q + 2'd1;
				end else begin
					bip_q <= '0;
					if (row_end) begin
						col_q <= '0;
						pad_q <= 2'd0 - wn_lo;
						if (row_q == 12'd0) row_q <= 12'(eff_h - 13'd1);
						else                row_q <= row_q - 12'd1;
					end else begin
						col_q <= col_q + 12'd1;
					end
				end
			end
		end
	end

	// read stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_fire && emit) s1_v_q <= 1'b1;
			else if (s1_move)    s1_v_q <= 1'b0;
			if (s1_move)         out_v_q <= s1_v_q;
		end
	end

	// read stage payload
	always_ff @(posedge clk) begin
		if (in_fire && emit) begin
			x_s1     <= col_q;
			y_s1     <= row_q;
			color_s1 <= pix_color;
			alpha_s1 <= pix_alpha;
			raw_s1   <= pix_raw;
			look_s1  <= pix_look;
			last_s1  <= (row_q == 12'd0) && row_end;
		end
	end

	// output register payload, palette colour merged in
	always_ff @(posedge clk) begin
		if (s1_move && s1_v_q) begin
			x_q     <= x_s1;
			y_q     <= y_s1;
			alpha_q <= alpha_s1;
			raw_q   <= raw_s1;
			last_q  <= last_s1;
			if (look_s1) color_q <= pal_rsp.hit ? pal_rsp.rdata : 24'h000000;
			else         color_q <= color_s1;
		end
	end

	assign out_valid  = out_v_q;
	assign pixel_x    = x_q;
	assign pixel_y    = y_q;
	assign blue       = color_q[7:0];
	assign green      = color_q[15:8];
	assign red        = color_q[23:16];
	assign alpha      = alpha_q;
	assign raw_grey   = raw_q;
	assign last_pixel = last_q;

endmodule

// ----- rtl/bmpd_checker.sv -----
// ----------------------------------------------------------------------------
// bmpd_checker
// Port-level checks of the BMP pixel stream decoder, bound to the top level.
// ----------------------------------------------------------------------------
module bmpd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [11:0] pixel_x,
	input logic [11:0] pixel_y,
	input logic [7:0]  blue,
	input logic [7:0]  green,
	input logic [7:0]  red,
	input logic [7:0]  alpha,
	input logic        raw_grey,
	input logic        last_pixel
);

	// a stalled pixel holds until its transfer
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(pixel_x) && $stable(pixel_y)
			&& $stable(blue) && $stable(last_pixel))
		else $error("stalled pixel changed");

	// a raw grey pixel carries its value in blue only
	a_raw_grey: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && raw_grey |-> green == 8'd0 && red == 8'd0 && alpha == 8'd0)
		else $error("raw grey pixel with colour");

	// the final pixel lies on the bottom row
	a_last_row: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && last_pixel |-> pixel_y == 12'd0)
		else $error("last pixel off bottom row");

	// a pixel can only follow an accepted byte
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("pixel without input byte");

endmodule

bind bmp_pixel_stream_decoder bmpd_checker u_bmpd_checker (.*);
